// ===== rtl/core/tesu_pkg.sv =====
package tesu_pkg;

    // default design parameters
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int COORD_FIELD_WIDTH = 32;
    localparam int MAT_WIDTH         = 32;
    localparam int VALUE_WIDTH       = 64;
    localparam int INDEX_WIDTH       = 3;
    localparam int PADDR_WIDTH       = 5;
    localparam int PDATA_WIDTH       = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_D11 = 3'd0;
    localparam logic [2:0] REG_D12 = 3'd1;
    localparam logic [2:0] REG_D13 = 3'd2;
    localparam logic [2:0] REG_D22 = 3'd3;
    localparam logic [2:0] REG_D23 = 3'd4;
    localparam logic [2:0] REG_D33 = 3'd5;

    // last row and column of the 6x6 matrix
    localparam logic [INDEX_WIDTH-1:0] LAST_INDEX = 3'd5;

    // input request: three vertices
    typedef struct packed {
        logic signed [COORD_FIELD_WIDTH-1:0] x_a;
        logic signed [COORD_FIELD_WIDTH-1:0] y_a;
        logic signed [COORD_FIELD_WIDTH-1:0] x_b;
        logic signed [COORD_FIELD_WIDTH-1:0] y_b;
        logic signed [COORD_FIELD_WIDTH-1:0] x_c;
        logic signed [COORD_FIELD_WIDTH-1:0] y_c;
    } t_tesu_req;

    // result: one matrix entry
    typedef struct packed {
        logic [INDEX_WIDTH-1:0]        row_index;
        logic [INDEX_WIDTH-1:0]        col_index;
        logic signed [VALUE_WIDTH-1:0] stiffness_value;
        logic                          degenerate;
        logic                          saturated;
        logic                          last;
    } t_tesu_rsp;

    // control that travels with an entry through the datapath
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] row;
        logic [INDEX_WIDTH-1:0] col;
        logic                   degen;
        logic                   neg;
        logic                   last;
    } t_tesu_tag;

endpackage

// ===== rtl/core/tesu_divider.sv =====
module tesu_divider #(
    parameter int NUM_WIDTH = 4 * tesu_pkg::COORD_WIDTH_DEF + 53,
    parameter int DEN_WIDTH = 2 * tesu_pkg::COORD_WIDTH_DEF + 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [NUM_WIDTH-1:0]              i_num,
    input  logic [DEN_WIDTH-1:0]              i_den,
    input  tesu_pkg::t_tesu_tag               i_tag,
    output logic                              o_valid,
    output logic [tesu_pkg::VALUE_WIDTH-1:0]  o_quo,
    output logic                              o_big,
    output tesu_pkg::t_tesu_tag               o_tag
);
    import tesu_pkg::*;

    localparam int QW = VALUE_WIDTH;
    localparam int RW = DEN_WIDTH + 1;

    logic                 r_vld [0:QW];
    logic [RW-1:0]        r_rem [0:QW];
    logic [QW-1:0]        r_nq  [0:QW];
    logic [DEN_WIDTH-1:0] r_den [0:QW];
    logic                 r_big [0:QW];
    t_tesu_tag            r_tag [0:QW];

    // load stage: quotient overflow check on the upper numerator bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_num[NUM_WIDTH-1:QW]);
            r_nq[0]  <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_big[0] <= RW'(i_num[NUM_WIDTH-1:QW]) >= RW'(i_den);
            r_tag[0] <= i_tag;
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [RW-1:0] w_trial;
        logic [RW:0]   w_diff;
        logic          w_bit;

        assign w_trial = {r_rem[k-1][RW-2:0], r_nq[k-1][QW-1]};
        assign w_diff  = {1'b0, w_trial} - {2'b00, r_den[k-1]};
        assign w_bit   = !w_diff[RW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_bit ? w_diff[RW-1:0] : w_trial;
                r_nq[k]  <= {r_nq[k-1][QW-2:0], w_bit};
                r_den[k] <= r_den[k-1];
                r_big[k] <= r_big[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_nq[QW];
    assign o_big   = r_big[QW];
    assign o_tag   = r_tag[QW];

endmodule

// ===== rtl/core/triangle_element_stiffness_unit.sv =====
// Constant-strain triangle stiffness unit.
// A request carries the three vertices of one triangle (Q16.16 by default). For
// each request the unit sends 36 results, the 6x6 element stiffness matrix in
// row-major order, one entry per cycle while the result side does not stall;
// the 36th entry carries last. Both channels use valid and stall; a beat moves
// when valid is high and stall low. The six material entries are written over
// the APB-style port; the user must write them only while the unit is idle, as
// the unit itself does not enforce this. Reads return the stored values.
// Request throughput is set by the result channel; the next request is taken
// while the current one is being issued, so back-to-back requests stream with
// no gaps. Each entry passes a multiply pipeline and a divider with a load stage
// and 64 further stages, one quotient bit per stage. A stall on the result side
// freezes the whole entry pipeline, holding every entry in place; the front
// stages keep filling until full, then stall the request side.
// Reset clears all valid bits and the material registers to zero.
module triangle_element_stiffness_unit #(
    parameter int COORD_WIDTH = tesu_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tesu_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  tesu_pkg::t_tesu_req              i_req,
    output logic                             o_valid,
    input  logic                             i_stall,
    output tesu_pkg::t_tesu_rsp              o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tesu_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [tesu_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [tesu_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                             pready
);
    import tesu_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int XW    = (CW < COORD_FIELD_WIDTH) ? CW : COORD_FIELD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int DETW  = 2 * DW + 1;
    localparam int AW    = 2 * DW;
    localparam int DNW   = AW + 1;
    localparam int TW    = DW + MAT_WIDTH;
    localparam int PW    = 2 * DW + MAT_WIDTH;
    localparam int SW    = PW + 2;
    localparam int SHIFT = 32 - FRAC_BITS;
    localparam int NW    = SW + SHIFT + 1;

    function automatic logic signed [DW-1:0] f_coord(input logic [COORD_FIELD_WIDTH-1:0] v);
        return DW'($signed(v[XW-1:0]));
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [MAT_WIDTH-1:0] r_d11, r_d12, r_d13, r_d22, r_d23, r_d33;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d11 <= '0;
            r_d12 <= '0;
            r_d13 <= '0;
            r_d22 <= '0;
            r_d23 <= '0;
            r_d33 <= '0;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_D11: r_d11 <= pwdata;
                REG_D12: r_d12 <= pwdata;
                REG_D13: r_d13 <= pwdata;
                REG_D22: r_d22 <= pwdata;
                REG_D23: r_d23 <= pwdata;
                REG_D33: r_d33 <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_D11: prdata = r_d11;
            REG_D12: prdata = r_d12;
            REG_D13: prdata = r_d13;
            REG_D22: prdata = r_d22;
            REG_D23: prdata = r_d23;
            REG_D33: prdata = r_d33;
            default: prdata = '0;
        endcase
    end

    // ---------------- front pipeline: per-request geometry ----------------
    logic                 w_en;
    logic                 w_load;
    logic                 w_adv1, w_adv2, w_adv3, w_adv4, w_adv5;

    logic                 r_f1_valid;
    logic signed [DW-1:0] r_f1_x [0:2];
    logic signed [DW-1:0] r_f1_y [0:2];

    logic                 r_f2_valid;
    logic signed [DW-1:0] r_f2_b [0:2];
    logic signed [DW-1:0] r_f2_c [0:2];
    logic signed [DW-1:0] r_f2_dx1, r_f2_dy2, r_f2_dx2, r_f2_dy1;

    logic                 r_f3_valid;
    logic signed [DW-1:0] r_f3_b [0:2];
    logic signed [DW-1:0] r_f3_c [0:2];
    logic signed [AW-1:0] r_f3_m1, r_f3_m2;

    logic                   r_f4_valid;
    logic signed [DW-1:0]   r_f4_b [0:2];
    logic signed [DW-1:0]   r_f4_c [0:2];
    logic signed [DETW-1:0] r_f4_det;

    logic                 r_f5_valid;
    logic signed [DW-1:0] r_f5_b [0:2];
    logic signed [DW-1:0] r_f5_c [0:2];
    logic [AW-1:0]        r_f5_abs;
    logic                 r_f5_neg;
    logic                 r_f5_degen;

    assign w_adv5  = !r_f5_valid || w_load;
    assign w_adv4  = !r_f4_valid || w_adv5;
    assign w_adv3  = !r_f3_valid || w_adv4;
    assign w_adv2  = !r_f2_valid || w_adv3;
    assign w_adv1  = !r_f1_valid || w_adv2;
    assign o_stall = !w_adv1;

    // front valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
            r_f4_valid <= 1'b0;
            r_f5_valid <= 1'b0;
        end else begin
            if (w_adv1) r_f1_valid <= i_valid;
            if (w_adv2) r_f2_valid <= r_f1_valid;
            if (w_adv3) r_f3_valid <= r_f2_valid;
            if (w_adv4) r_f4_valid <= r_f3_valid;
            if (w_adv5) r_f5_valid <= r_f4_valid;
        end
    end

    // capture coordinates
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_f1_x[0] <= f_coord(i_req.x_a);
            r_f1_y[0] <= f_coord(i_req.y_a);
            r_f1_x[1] <= f_coord(i_req.x_b);
            r_f1_y[1] <= f_coord(i_req.y_b);
            r_f1_x[2] <= f_coord(i_req.x_c);
            r_f1_y[2] <= f_coord(i_req.y_c);
        end
    end

    // edge differences
    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_f2_b[0] <= r_f1_y[1] - r_f1_y[2];
            r_f2_b[1] <= r_f1_y[2] - r_f1_y[0];
            r_f2_b[2] <= r_f1_y[0] - r_f1_y[1];
            r_f2_c[0] <= r_f1_x[2] - r_f1_x[1];
            r_f2_c[1] <= r_f1_x[0] - r_f1_x[2];
            r_f2_c[2] <= r_f1_x[1] - r_f1_x[0];
            r_f2_dx1  <= r_f1_x[1] - r_f1_x[0];
            r_f2_dy2  <= r_f1_y[2] - r_f1_y[0];
            r_f2_dx2  <= r_f1_x[2] - r_f1_x[0];
            r_f2_dy1  <= r_f1_y[1] - r_f1_y[0];
        end
    end

    // determinant cross products
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_f3_b  <= r_f2_b;
            r_f3_c  <= r_f2_c;
            r_f3_m1 <= r_f2_dx1 * r_f2_dy2;
            r_f3_m2 <= r_f2_dx2 * r_f2_dy1;
        end
    end

    // determinant
    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r_f4_b   <= r_f3_b;
            r_f4_c   <= r_f3_c;
            r_f4_det <= DETW'(r_f3_m1) - DETW'(r_f3_m2);
        end
    end

    // magnitude, sign and zero test of the determinant
    always_ff @(posedge i_clk) begin
        if (w_adv5) begin
            r_f5_b     <= r_f4_b;
            r_f5_c     <= r_f4_c;
            r_f5_neg   <= r_f4_det[DETW-1];
            r_f5_degen <= (r_f4_det == '0);
            r_f5_abs   <= r_f4_det[DETW-1] ? AW'(-r_f4_det) : AW'(r_f4_det);
        end
    end

    // ---------------- entry sequencer ----------------
    logic                   r_it_valid;
    logic signed [DW-1:0]   r_sb [0:2];
    logic signed [DW-1:0]   r_sc [0:2];
    logic [AW-1:0]          r_sabs;
    logic                   r_sneg;
    logic                   r_sdegen;
    logic [INDEX_WIDTH-1:0] r_p, r_q;
    logic                   w_last;

    assign w_last = (r_p == LAST_INDEX) && (r_q == LAST_INDEX);
    assign w_load = w_en && r_f5_valid && (!r_it_valid || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_valid <= 1'b0;
            r_p        <= '0;
            r_q        <= '0;
        end else if (w_en) begin
            if (w_load) begin
                r_it_valid <= 1'b1;
                r_p        <= '0;
                r_q        <= '0;
            end else if (r_it_valid) begin
                if (w_last) begin
                    r_it_valid <= 1'b0;
                end
                if (r_q == LAST_INDEX) begin
                    r_q <= '0;
                    r_p <= r_p + 1'b1;
                end else begin
                    r_q <= r_q + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_sb     <= r_f5_b;
            r_sc     <= r_f5_c;
            r_sabs   <= r_f5_abs;
            r_sneg   <= r_f5_neg;
            r_sdegen <= r_f5_degen;
        end
    end

    // operand selection for entry (p, q)
    logic signed [DW-1:0]        w_up, w_vp, w_uq, w_vq;
    logic signed [DW-1:0]        w_bp, w_cp, w_bq, w_cq;
    logic signed [MAT_WIDTH-1:0] w_dpq, w_dp2, w_d2q;

    always_comb begin
        unique case (r_p[2:1])
            2'd0:    begin w_bp = r_sb[0]; w_cp = r_sc[0]; end
            2'd1:    begin w_bp = r_sb[1]; w_cp = r_sc[1]; end
            default: begin w_bp = r_sb[2]; w_cp = r_sc[2]; end
        endcase
        unique case (r_q[2:1])
            2'd0:    begin w_bq = r_sb[0]; w_cq = r_sc[0]; end
            2'd1:    begin w_bq = r_sb[1]; w_cq = r_sc[1]; end
            default: begin w_bq = r_sb[2]; w_cq = r_sc[2]; end
        endcase
        unique case ({r_p[0], r_q[0]})
            2'b00:   w_dpq = r_d11;
            2'b11:   w_dpq = r_d22;
            default: w_dpq = r_d12;
        endcase
    end

    assign w_up  = r_p[0] ? w_cp : w_bp;
    assign w_vp  = r_p[0] ? w_bp : w_cp;
    assign w_uq  = r_q[0] ? w_cq : w_bq;
    assign w_vq  = r_q[0] ? w_bq : w_cq;
    assign w_dp2 = r_p[0] ? r_d23 : r_d13;
    assign w_d2q = r_q[0] ? r_d23 : r_d13;

    // ---------------- entry pipeline ----------------
    logic                 r_out_valid;
    t_tesu_rsp            r_out;

    assign w_en = !r_out_valid || !i_stall;

    logic                      r_e1_valid;
    t_tesu_tag                 r_e1_tag;
    logic [AW-1:0]             r_e1_abs;
    logic signed [TW-1:0]      r_e1_t [0:3];
    logic signed [DW-1:0]      r_e1_w [0:3];

    logic                      r_e2_valid;
    t_tesu_tag                 r_e2_tag;
    logic [AW-1:0]             r_e2_abs;
    logic signed [2*DW-1:0]    r_e2_ph [0:3];
    logic signed [DW+32:0]     r_e2_pl [0:3];

    logic                      r_e3_valid;
    t_tesu_tag                 r_e3_tag;
    logic [AW-1:0]             r_e3_abs;
    logic signed [PW-1:0]      r_e3_term [0:3];

    logic                      r_e4_valid;
    t_tesu_tag                 r_e4_tag;
    logic [AW-1:0]             r_e4_abs;
    logic signed [SW-1:0]      r_e4_s;

    logic                      r_e5_valid;
    t_tesu_tag                 r_e5_tag;
    logic [AW-1:0]             r_e5_abs;
    logic [SW-1:0]             r_e5_mag;

    logic                      r_e6_valid;
    t_tesu_tag                 r_e6_tag;
    logic [NW-1:0]             r_e6_num;
    logic [DNW-1:0]            r_e6_den;

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_valid <= 1'b0;
            r_e2_valid <= 1'b0;
            r_e3_valid <= 1'b0;
            r_e4_valid <= 1'b0;
            r_e5_valid <= 1'b0;
            r_e6_valid <= 1'b0;
        end else if (w_en) begin
            r_e1_valid <= r_it_valid;
            r_e2_valid <= r_e1_valid;
            r_e3_valid <= r_e2_valid;
            r_e4_valid <= r_e3_valid;
            r_e5_valid <= r_e4_valid;
            r_e6_valid <= r_e5_valid;
        end
    end

    // first products: edge term times material entry
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_tag.row   <= r_p;
            r_e1_tag.col   <= r_q;
            r_e1_tag.degen <= r_sdegen;
            r_e1_tag.neg   <= r_sneg;
            r_e1_tag.last  <= w_last;
            r_e1_abs       <= r_sabs;
            r_e1_t[0]      <= w_up * w_dpq;
            r_e1_t[1]      <= w_up * w_dp2;
            r_e1_t[2]      <= w_vp * w_d2q;
            r_e1_t[3]      <= w_vp * r_d33;
            r_e1_w[0]      <= w_uq;
            r_e1_w[1]      <= w_vq;
            r_e1_w[2]      <= w_uq;
            r_e1_w[3]      <= w_vq;
        end
    end

    // second products, split into high and low partial products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_tag <= r_e1_tag;
            r_e2_abs <= r_e1_abs;
            for (int j = 0; j < 4; j++) begin
                r_e2_ph[j] <= $signed(r_e1_t[j][TW-1:32]) * r_e1_w[j];
                r_e2_pl[j] <= $signed({1'b0, r_e1_t[j][31:0]}) * r_e1_w[j];
            end
        end
    end

    // recombine partial products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e3_tag <= r_e2_tag;
            r_e3_abs <= r_e2_abs;
            for (int j = 0; j < 4; j++) begin
                r_e3_term[j] <= (PW'(r_e2_ph[j]) <<< 32) + PW'(r_e2_pl[j]);
            end
        end
    end

    // sum of the four terms
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e4_tag <= r_e3_tag;
            r_e4_abs <= r_e3_abs;
            r_e4_s   <= SW'(r_e3_term[0]) + SW'(r_e3_term[1])
                      + SW'(r_e3_term[2]) + SW'(r_e3_term[3]);
        end
    end

    // magnitude and result sign
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e5_tag.row   <= r_e4_tag.row;
            r_e5_tag.col   <= r_e4_tag.col;
            r_e5_tag.degen <= r_e4_tag.degen;
            r_e5_tag.last  <= r_e4_tag.last;
            r_e5_tag.neg   <= r_e4_tag.neg ^ r_e4_s[SW-1];
            r_e5_abs       <= r_e4_abs;
            r_e5_mag       <= r_e4_s[SW-1] ? SW'(-r_e4_s) : r_e4_s;
        end
    end

    // rounded-division operands: (|S|*2^shift + |det|) / (2|det|)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e6_tag <= r_e5_tag;
            r_e6_num <= (NW'(r_e5_mag) << SHIFT) + NW'(r_e5_abs);
            r_e6_den <= {r_e5_abs, 1'b0};
        end
    end

    // ---------------- divider ----------------
    logic                   w_div_valid;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic                   w_big;
    t_tesu_tag              w_div_tag;

    tesu_divider #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (DNW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_e6_valid),
        .i_num   (r_e6_num),
        .i_den   (r_e6_den),
        .i_tag   (r_e6_tag),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_big   (w_big),
        .o_tag   (w_div_tag)
    );

    // ---------------- saturation, sign and output register ----------------
    t_tesu_rsp w_rsp;
    logic      w_sat;

    always_comb begin
        w_sat = w_big || (w_div_tag.neg ? (w_quo[VALUE_WIDTH-1] && |w_quo[VALUE_WIDTH-2:0])
                                        : w_quo[VALUE_WIDTH-1]);
        w_rsp.row_index  = w_div_tag.row;
        w_rsp.col_index  = w_div_tag.col;
        w_rsp.degenerate = w_div_tag.degen;
        w_rsp.last       = w_div_tag.last;
        if (w_div_tag.degen) begin
            w_rsp.stiffness_value = '0;
            w_rsp.saturated       = 1'b0;
        end else if (w_sat) begin
            w_rsp.stiffness_value = w_div_tag.neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                                  : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            w_rsp.saturated       = 1'b1;
        end else begin
            w_rsp.stiffness_value = w_div_tag.neg ? -$signed(w_quo) : $signed(w_quo);
            w_rsp.saturated       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_div_valid) begin
            r_out <= w_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== tb/tb_triangle_element_stiffness_unit.sv =====
`timescale 1ns / 1ps

module tb_triangle_element_stiffness_unit;
    import tesu_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int DRAIN     = 200;
    localparam int LIMIT     = 400000;

    typedef logic signed [191:0] t_wide;
    typedef enum int {CHK_MODEL, CHK_ZERO, CHK_DEGEN} t_chk;
    typedef struct {
        t_tesu_req req;
        t_chk      chk;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    t_tesu_req              i_req;
    logic                   o_valid;
    logic                   i_stall;
    t_tesu_rsp              o_rsp;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [PDATA_WIDTH-1:0] pwdata;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;

    // material matrix as the predictor sees it
    logic signed [MAT_WIDTH-1:0] mat_mirror [6];
    t_tesu_rsp entries_due [$];
    int  mismatches = 0;
    int  cycles = 0;
    int  triangles_sent = 0;
    int  entries_seen = 0;
    int  degen_seen = 0;
    int  sat_seen = 0;
    bit  quiet = 0;

    triangle_element_stiffness_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock and run limit
    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_triangle_element_stiffness_unit NOT OK");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_stall = quiet ? 1'b0 : ($urandom_range(99) < 23);
    end

    function automatic void report(string what, longint unsigned exp_v,
                                   longint unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
    endfunction

    // expected 6x6 stiffness entries for one triangle
    function automatic void predict_stiffness(t_tesu_req r, t_chk chk);
        t_wide x [3];
        t_wide y [3];
        t_wide col [6][3];
        t_wide dm [3][3];
        t_wide det, s, mag, dabs;
        logic [191:0] quo;
        logic [63:0] lo, lim;
        logic neg, sat;
        t_tesu_rsp e;
        int i, j1, j2;
        x[0] = r.x_a; y[0] = r.y_a;
        x[1] = r.x_b; y[1] = r.y_b;
        x[2] = r.x_c; y[2] = r.y_c;
        for (i = 0; i < 3; i++) begin
            j1 = (i + 1) % 3;
            j2 = (i + 2) % 3;
            col[2*i][0] = y[j1] - y[j2];
            col[2*i][1] = 0;
            col[2*i][2] = x[j2] - x[j1];
            col[2*i+1][0] = 0;
            col[2*i+1][1] = x[j2] - x[j1];
            col[2*i+1][2] = y[j1] - y[j2];
        end
        dm[0][0] = mat_mirror[REG_D11];
        dm[0][1] = mat_mirror[REG_D12]; dm[1][0] = dm[0][1];
        dm[0][2] = mat_mirror[REG_D13]; dm[2][0] = dm[0][2];
        dm[1][1] = mat_mirror[REG_D22];
        dm[1][2] = mat_mirror[REG_D23]; dm[2][1] = dm[1][2];
        dm[2][2] = mat_mirror[REG_D33];
        det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
        dabs = det < 0 ? -det : det;
        for (int p = 0; p < 6; p++) begin
            for (int q = 0; q < 6; q++) begin
                e = '0;
                e.row_index = p[INDEX_WIDTH-1:0];
                e.col_index = q[INDEX_WIDTH-1:0];
                e.last = (p == 5 && q == 5);
                if (chk == CHK_DEGEN) begin
                    e.degenerate = 1'b1;
                end else if (chk == CHK_MODEL && det == 0) begin
                    e.degenerate = 1'b1;
                end else if (chk == CHK_MODEL) begin
                    s = 0;
                    for (int k = 0; k < 3; k++)
                        for (int l = 0; l < 3; l++)
                            s = s + col[p][k] * dm[k][l] * col[q][l];
                    s = s <<< (31 - FRAC);
                    neg = (s < 0) != (det < 0);
                    mag = s < 0 ? -s : s;
                    quo = (2 * mag + dabs) / (2 * dabs);
                    lo = quo[63:0];
                    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
                    sat = (|quo[191:64]) || (lo > lim);
                    if (sat) lo = lim;
                    e.saturated = sat;
                    e.stiffness_value = neg ? -lo : lo;
                end
                entries_due.push_back(e);
            end
        end
    endfunction

    // result checking
    always @(posedge i_clk) begin
        t_tesu_rsp e;
        if (i_rst_n && o_valid && !i_stall) begin
            entries_seen++;
            degen_seen += o_rsp.degenerate;
            sat_seen += o_rsp.saturated;
            if (entries_due.size() == 0) begin
                report("unexpected entry", 0, o_rsp.stiffness_value);
            end else begin
                e = entries_due.pop_front();
                if (o_rsp.row_index !== e.row_index)
                    report("row_index", e.row_index, o_rsp.row_index);
                if (o_rsp.col_index !== e.col_index)
                    report("col_index", e.col_index, o_rsp.col_index);
                if (o_rsp.stiffness_value !== e.stiffness_value)
                    report("stiffness_value", e.stiffness_value, o_rsp.stiffness_value);
                if (o_rsp.degenerate !== e.degenerate)
                    report("degenerate", e.degenerate, o_rsp.degenerate);
                if (o_rsp.saturated !== e.saturated)
                    report("saturated", e.saturated, o_rsp.saturated);
                if (o_rsp.last !== e.last)
                    report("last", e.last, o_rsp.last);
            end
        end
    end

    // register write and readback, called at a falling edge
    task automatic write_mat(logic [2:0] idx, logic [31:0] value);
        psel = 1; penable = 0; pwrite = 1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        mat_mirror[idx] = value;
    endtask

    task automatic read_mat(logic [2:0] idx);
        psel = 1; penable = 0; pwrite = 0;
        paddr = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        if (prdata !== mat_mirror[idx])
            report("register readback", mat_mirror[idx], prdata);
        @(negedge i_clk);
        psel = 0; penable = 0;
    endtask

    task automatic load_material(logic [31:0] d11, logic [31:0] d12, logic [31:0] d13,
                                 logic [31:0] d22, logic [31:0] d23, logic [31:0] d33);
        write_mat(REG_D11, d11);
        write_mat(REG_D12, d12);
        write_mat(REG_D13, d13);
        write_mat(REG_D22, d22);
        write_mat(REG_D23, d23);
        write_mat(REG_D33, d33);
        for (int i = 0; i < 6; i++) read_mat(i[2:0]);
    endtask

    // wait until every entry is back and the pipeline is empty
    task automatic drain();
        while (entries_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // send one triangle request, starting and ending at a falling edge
    task automatic send_triangle(t_tesu_req r, t_chk chk);
        while (!quiet && $urandom_range(99) < 23) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_req = r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_stiffness(r, chk);
        triangles_sent++;
        @(negedge i_clk);
        i_valid = 0;
    endtask

    function automatic t_tesu_req rand_triangle();
        t_tesu_req r;
        logic signed [31:0] bx, by;
        int span;
        if ($urandom_range(99) < 25) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            // well-shaped small triangle at a random spot
            span = 1 << $urandom_range(20, 8);
            bx = $urandom;
            by = $urandom;
            bx = bx >>> 2;
            by = by >>> 2;
            r.x_a = bx; r.y_a = by;
            r.x_b = bx + $signed($urandom_range(span)) - span / 4;
            r.y_b = by + $signed($urandom_range(span / 2));
            r.x_c = bx + $signed($urandom_range(span / 2)) - span / 4;
            r.y_c = by + $signed($urandom_range(span)) - span / 4;
            if ($urandom_range(9) == 0) begin
                // collinear
                r.x_c = 2 * r.x_b - r.x_a;
                r.y_c = 2 * r.y_b - r.y_a;
            end
        end
        return r;
    endfunction

    localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINC = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    t_row zero_rows [3] = '{
        '{'{0, 0, ONE, 0, 0, ONE}, CHK_ZERO},
        '{'{MINC, MINC, MAXC, MINC, MINC, MAXC}, CHK_ZERO},
        '{'{0, 0, 0, 0, 0, 0}, CHK_DEGEN}
    };

    t_row shape_rows [14] = '{
        '{'{0, 0, ONE, 0, 0, ONE}, CHK_MODEL},
        '{'{0, 0, 0, ONE, ONE, 0}, CHK_MODEL},
        '{'{ONE, ONE, ONE, ONE, ONE, ONE}, CHK_DEGEN},
        '{'{0, 0, ONE, ONE, 2*ONE, 2*ONE}, CHK_DEGEN},
        '{'{0, 0, 1, 0, 0, 1}, CHK_MODEL},
        '{'{0, 0, 1, 0, 0, -1}, CHK_MODEL},
        '{'{MINC, MINC, MAXC, MINC, MINC, MAXC}, CHK_MODEL},
        '{'{MAXC, MAXC, MINC, MAXC, MAXC, MINC}, CHK_MODEL},
        '{'{MINC, MAXC, MAXC, MAXC, MINC, MINC}, CHK_MODEL},
        '{'{-ONE, -ONE, 3*ONE, -2*ONE, ONE, 5*ONE}, CHK_MODEL},
        '{'{0, 0, 1, 0, 0, 32'sh7fff_ffff}, CHK_MODEL},
        '{'{0, 0, MAXC, 0, 0, 1}, CHK_MODEL},
        '{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
            32'sh0f0f_0f0f, 32'shf0f0_f0f0}, CHK_MODEL},
        '{'{7, -3, -5, 11, 2, 9}, CHK_MODEL}
    };

    initial begin
        i_rst_n = 0; i_valid = 0; i_req = '0; i_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        for (int i = 0; i < 6; i++) mat_mirror[i] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // material cleared by reset: every entry zero
        for (int i = 0; i < 6; i++) read_mat(i[2:0]);
        foreach (zero_rows[i]) send_triangle(zero_rows[i].req, zero_rows[i].chk);
        drain();

        // plane-stress-like material, directed shapes then random
        load_material(32'h0001_0000, 32'h0000_4ccd, 32'h0000_0000,
                      32'h0001_0000, 32'h0000_0000, 32'h0000_5999);
        foreach (shape_rows[i]) send_triangle(shape_rows[i].req, shape_rows[i].chk);
        for (int n = 0; n < 40; n++) begin
            if (n == 20) begin
                // let everything drain before going on
                while (entries_due.size() != 0) @(negedge i_clk);
            end
            send_triangle(rand_triangle(), CHK_MODEL);
        end
        drain();

        // extreme material: all positive full scale
        load_material(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
        foreach (shape_rows[i]) if (i >= 6 && i < 9)
            send_triangle(shape_rows[i].req, shape_rows[i].chk);
        for (int n = 0; n < 35; n++) send_triangle(rand_triangle(), CHK_MODEL);
        drain();

        // extreme material: all negative full scale
        load_material(MINC, MINC, MINC, MINC, MINC, MINC);
        foreach (shape_rows[i]) if (i >= 6 && i < 9)
            send_triangle(shape_rows[i].req, shape_rows[i].chk);
        for (int n = 0; n < 35; n++) send_triangle(rand_triangle(), CHK_MODEL);
        drain();

        // random materials, with a stretch of full-rate traffic
        for (int ph = 0; ph < 3; ph++) begin
            load_material($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            for (int n = 0; n < 35; n++) begin
                quiet = (ph == 1);
                send_triangle(rand_triangle(), CHK_MODEL);
            end
            quiet = 0;
            drain();
        end

        $display("%0d triangles over 7 material settings, %0d entries checked",
                 triangles_sent, entries_seen);
        $display("%0d degenerate and %0d saturated entries, %0d mismatches",
                 degen_seen, sat_seen, mismatches);
        if (mismatches == 0 && entries_due.size() == 0) begin
            $display("tb_triangle_element_stiffness_unit OK");
        end else begin
            $display("tb_triangle_element_stiffness_unit NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tesu_pkg.sv
rtl/core/tesu_divider.sv
rtl/core/triangle_element_stiffness_unit.sv
tb/tb_triangle_element_stiffness_unit.sv
